// ----- rtl/core/text_mode_character_video_macros.svh -----
// Assertion macros shared by the character video RTL.
`ifndef TEXT_MODE_CHARACTER_VIDEO_MACROS_SVH
`define TEXT_MODE_CHARACTER_VIDEO_MACROS_SVH

// Condition must never hold outside reset.
`define TMCV_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define TMCV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tmcv_pkg.sv -----
`timescale 1ns / 1ps

package tmcv_pkg;

	// Default raster geometry
	localparam int DEF_TEXT_ROWS     = 16;
	localparam int DEF_LINES_PER_ROW = 12;
	localparam int DEF_CELLS_PER_ROW = 64;

	// Store geometry
	localparam int CHAR_AW  = 10;
	localparam int GLYPH_AW = 12;
	localparam int CODE_W   = 8;
	localparam int LINE_FW  = 4;   // glyph stride is 16 bytes, one per scanline

	// Queue depths
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Request action codes
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_CHAR  = 2'd1;
	localparam logic [1:0] ACT_GLYPH = 2'd2;

	// Position and flags of one slice
	typedef struct packed {
		logic [3:0] text_row;
		logic [3:0] scanline;
		logic [5:0] column;
		logic       line_end;
		logic       frame_end;
	} meta_t;

	// Request passed from front to back
	typedef struct packed {
		logic [1:0]          kind;
		logic [GLYPH_AW-1:0] addr;   // char address for ticks, store address for writes
		logic [7:0]          data;
		meta_t               meta;
	} entry_t;

	// One finished slice
	typedef struct packed {
		logic [5:0] pixels;
		meta_t      meta;
	} result_t;

endpackage

// ----- rtl/core/tmcv_fifo.sv -----
`timescale 1ns / 1ps

module tmcv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (!do_wr && do_rd) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/tmcv_front.sv -----
`timescale 1ns / 1ps

module tmcv_front #(
	parameter int TEXT_ROWS     = tmcv_pkg::DEF_TEXT_ROWS,
	parameter int LINES_PER_ROW = tmcv_pkg::DEF_LINES_PER_ROW,
	parameter int CELLS_PER_ROW = tmcv_pkg::DEF_CELLS_PER_ROW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       action,
	input  logic [11:0]      address,
	input  logic [7:0]       write_data,
	input  logic             cfg_we,
	input  logic             cfg_data,
	output logic             enq,
	output tmcv_pkg::entry_t entry
);
	import tmcv_pkg::*;

	localparam int ROW_W     = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
	localparam int LINE_W    = (LINES_PER_ROW > 1) ? $clog2(LINES_PER_ROW) : 1;
	localparam int CELL_W    = $clog2(CELLS_PER_ROW);
	localparam int COLS_WIDE = (CELLS_PER_ROW + 1) / 2;

	logic [ROW_W-1:0]   row_q;
	logic [LINE_W-1:0]  line_q;
	logic [CELL_W-1:0]  cell_q;
	logic               wide_q;
	logic [CELL_W-1:0]  last_cell;
	logic [CELL_W-1:0]  cell_idx;
	logic [CHAR_AW-1:0] caddr;
	logic               is_tick;
	logic               lend, lline, lrow;

	// Position of the current slice
	assign last_cell = wide_q ? CELL_W'(COLS_WIDE - 1) : CELL_W'(CELLS_PER_ROW - 1);
	assign cell_idx  = wide_q ? (cell_q << 1) : cell_q;
	assign caddr     = CHAR_AW'(32'(row_q) * 32'(CELLS_PER_ROW) + 32'(cell_idx));
	assign lend      = (cell_q == last_cell);
	assign lline     = (line_q == LINE_W'(LINES_PER_ROW - 1));
	assign lrow      = (row_q == ROW_W'(TEXT_ROWS - 1));

	// Classify and build the queued request
	assign is_tick = accept && (action == ACT_TICK);
	assign enq     = accept && (action inside {ACT_TICK, ACT_CHAR, ACT_GLYPH});

	always_comb begin
		entry.kind           = action;
		entry.data           = write_data;
		entry.addr           = is_tick ? GLYPH_AW'(caddr) : address;
		entry.meta.text_row  = 4'(row_q);
		entry.meta.scanline  = 4'(line_q);
		entry.meta.column    = 6'(cell_q);
		entry.meta.line_end  = lend;
		entry.meta.frame_end = lend && lline && lrow;
	end

	// Raster counters and mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
			cell_q <= '0;
			line_q <= '0;
			row_q  <= '0;
		end else if (cfg_we) begin
			wide_q <= cfg_data;
			cell_q <= '0;
			line_q <= '0;
			row_q  <= '0;
		end else if (is_tick) begin
			if (!lend) begin
				cell_q <= cell_q + 1'b1;
			end else begin
				cell_q <= '0;
				if (!lline) begin
					line_q <= line_q + 1'b1;
				end else begin
					line_q <= '0;
					row_q  <= lrow ? '0 : row_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/tmcv_back.sv -----
`timescale 1ns / 1ps

module tmcv_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mid_empty,
	input  tmcv_pkg::entry_t              head,
	output logic                          mid_pop,
	input  logic [tmcv_pkg::OUT_CNT_W-1:0] out_count,
	output logic                          out_push,
	output tmcv_pkg::result_t             out_data
);
	import tmcv_pkg::*;

	localparam int SUM_W = OUT_CNT_W + 2;

	logic [7:0] char_mem  [2**CHAR_AW];
	logic [7:0] glyph_mem [2**GLYPH_AW];

	logic                vld_s1, vld_s2;
	logic [1:0]          kind_s1;
	logic [GLYPH_AW-1:0] addr_s1;
	logic [7:0]          data_s1;
	meta_t               meta_s1, meta_s2;
	logic [CODE_W-1:0]   code_s1;
	logic [5:0]          pix_s2;
	logic                tick_s1, head_tick, room;
	logic [SUM_W-1:0]    claimed;

	// Reserve result space for every slice in flight
	assign tick_s1   = vld_s1 && (kind_s1 == ACT_TICK);
	assign head_tick = (head.kind == ACT_TICK);
	assign claimed   = SUM_W'(out_count) + SUM_W'(tick_s1) + SUM_W'(vld_s2);
	assign room      = (claimed < SUM_W'(OUT_DEPTH));
	assign mid_pop   = !mid_empty && (!head_tick || room);

	// Stage 1: character store write or code fetch
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			if (head.kind == ACT_CHAR) begin
				char_mem[head.addr[CHAR_AW-1:0]] <= head.data;
			end
			code_s1 <= char_mem[head.addr[CHAR_AW-1:0]];
			kind_s1 <= head.kind;
			addr_s1 <= head.addr;
			data_s1 <= head.data;
			meta_s1 <= head.meta;
		end
	end

	// Stage 2: glyph store write or pattern fetch at code*16 + scanline
	always_ff @(posedge clk) begin
		if (vld_s1 && (kind_s1 == ACT_GLYPH)) begin
			glyph_mem[addr_s1] <= data_s1;
		end
		if (tick_s1) begin
			pix_s2  <= glyph_mem[{code_s1, meta_s1.scanline}][5:0];
			meta_s2 <= meta_s1;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= mid_pop;
			vld_s2 <= tick_s1;
		end
	end

	assign out_push      = vld_s2;
	assign out_data.pixels = pix_s2;
	assign out_data.meta   = meta_s2;

endmodule

// ----- rtl/core/text_mode_character_video.sv -----
// A tick request goes through the request queue, stage 1, stage 2 and the result queue.
// Throughput: one request per cycle, sustained, while results are popped each cycle.
// Store writes take one slot each and give no result.
// Reset clears counters, mode register and queues; the character and glyph stores keep content.
// A mode write restarts the frame at row 0, scanline 0, column 0.
`timescale 1ns / 1ps
`include "text_mode_character_video_macros.svh"

module text_mode_character_video #(
	parameter int TEXT_ROWS     = tmcv_pkg::DEF_TEXT_ROWS,
	parameter int LINES_PER_ROW = tmcv_pkg::DEF_LINES_PER_ROW,
	parameter int CELLS_PER_ROW = tmcv_pkg::DEF_CELLS_PER_ROW
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	input  logic        cfg_we,
	input  logic        cfg_data,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  pixels,
	output logic [3:0]  text_row,
	output logic [3:0]  scanline,
	output logic [5:0]  column,
	output logic        line_end,
	output logic        frame_end
);
	import tmcv_pkg::*;

	logic                             accept;
	logic                             enq;
	entry_t                           enq_entry, head;
	logic                             mid_empty, mid_pop;
	logic [$clog2(MID_DEPTH + 1)-1:0] mid_count;
	logic [OUT_CNT_W-1:0]             out_count;
	logic                             out_push, out_full;
	result_t                          out_data, out_head;

	assign accept = push && !full;

	// Front: counters and request classification
	tmcv_front #(
		.TEXT_ROWS    (TEXT_ROWS),
		.LINES_PER_ROW(LINES_PER_ROW),
		.CELLS_PER_ROW(CELLS_PER_ROW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.address   (address),
		.write_data(write_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.enq       (enq),
		.entry     (enq_entry)
	);

	// Queue between front and back
	tmcv_fifo #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (enq),
		.wr_data(enq_entry),
		.rd_en  (mid_pop),
		.rd_data(head),
		.full   (full),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	// Back: store access and glyph lookup
	tmcv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(mid_empty),
		.head     (head),
		.mid_pop  (mid_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_data (out_data)
	);

	// Result queue
	tmcv_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_push),
		.wr_data(out_data),
		.rd_en  (pop),
		.rd_data(out_head),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	assign pixels    = out_head.pixels;
	assign text_row  = out_head.meta.text_row;
	assign scanline  = out_head.meta.scanline;
	assign column    = out_head.meta.column;
	assign line_end  = out_head.meta.line_end;
	assign frame_end = out_head.meta.frame_end;

	// Checks
	`TMCV_ASSERT_NEVER(a_out_no_overflow, clk, arst_n, out_push && out_full, "result overflow")
	`TMCV_ASSERT_NEVER(a_mid_no_underflow, clk, arst_n, mid_pop && mid_empty, "request underflow")
	`TMCV_ASSERT_NEVER(a_mid_count, clk, arst_n, int'(mid_count) > MID_DEPTH, "bad request count")
	`TMCV_ASSERT_IMPLIES(a_frame_end, clk, arst_n, !empty && frame_end, line_end, "lone frame end")

endmodule
